@@ rtl/i2cms_pkg.sv @@
// Package for the I2C master transfer sequencer: phase and command codes,
// and the item structs passed between the sequencer modules. No dependencies.
package i2cms_pkg;

    typedef enum logic [4:0] {
        PH_UNINIT     = 5'd0,
        PH_IDLE       = 5'd1,
        PH_START      = 5'd2,
        PH_START_POLL = 5'd3,
        PH_ADDR       = 5'd4,
        PH_ADDR_POLL  = 5'd5,
        PH_CLEAR      = 5'd6,
        PH_PLACE      = 5'd7,
        PH_PLACE_POLL = 5'd8,
        PH_PLACE_NEXT = 5'd9,
        PH_GET_NEXT   = 5'd10,
        PH_LAST_POLL  = 5'd11,
        PH_LAST_GET   = 5'd12,
        PH_MULTI_POLL = 5'd13,
        PH_MULTI_GET  = 5'd14
    } t_phase;

    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_START      = 4'd1,
        CMD_POLL_START = 4'd2,
        CMD_SEND_ADDR  = 4'd3,
        CMD_POLL_ADDR  = 4'd4,
        CMD_CLEAR_ADDR = 4'd5,
        CMD_PLACE      = 4'd6,
        CMD_POLL_PLACE = 4'd7,
        CMD_ACK_OFF    = 4'd8,
        CMD_POLL_GET   = 4'd9,
        CMD_GET        = 4'd10,
        CMD_ACK_ON     = 4'd11
    } t_cmd;

    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic       init_done;
        logic [1:0] req_type;
        logic [6:0] slave_address;
        logic [7:0] byte_count;
        logic       driver_ok;
    } t_in_item;

    typedef struct packed {
        t_cmd       command;
        logic [6:0] address_out;
        logic       read_not_write;
        logic [7:0] byte_index;
        logic       tx_done;
        logic       rx_done;
    } t_out_item;

endpackage

@@ rtl/i2cms_fsm.sv @@
// Phase machine of the I2C master transfer sequencer: holds the transfer
// state and computes one driver command per step. Depends on i2cms_pkg.
module i2cms_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cms_pkg::t_in_item i_item,
    output i2cms_pkg::t_out_item o_result
);

    i2cms_pkg::t_phase r_phase, n_phase;
    i2cms_pkg::t_phase r_ret, n_ret;
    logic       r_wr_pend, n_wr_pend;
    logic       r_rd_pend, n_rd_pend;
    logic [6:0] r_addr, n_addr;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_pos, n_pos;

    // State as seen after a new request of this item has been recorded.
    logic       e_wr_pend, e_rd_pend;
    logic [6:0] e_addr;
    logic [7:0] e_cnt, e_pos;
    logic       new_req;
    logic       cnt_last;

    always_comb begin
        new_req   = (i_item.req_type == i2cms_pkg::REQ_WRITE ||
                     i_item.req_type == i2cms_pkg::REQ_READ) &&
                    (i_item.byte_count != 8'd0);
        e_wr_pend = r_wr_pend | (new_req && i_item.req_type == i2cms_pkg::REQ_WRITE);
        e_rd_pend = r_rd_pend | (new_req && i_item.req_type == i2cms_pkg::REQ_READ);
        e_addr    = new_req ? i_item.slave_address : r_addr;
        e_cnt     = new_req ? i_item.byte_count : r_cnt;
        e_pos     = new_req ? 8'd0 : r_pos;
        cnt_last  = (e_cnt <= 8'd1);
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_ret     = r_ret;
        n_wr_pend = e_wr_pend;
        n_rd_pend = e_rd_pend;
        n_addr    = e_addr;
        n_cnt     = e_cnt;
        n_pos     = e_pos;
        case (r_phase)
            i2cms_pkg::PH_IDLE: begin
                if (e_wr_pend || e_rd_pend) n_phase = i2cms_pkg::PH_START;
            end
            i2cms_pkg::PH_START: n_phase = i2cms_pkg::PH_START_POLL;
            i2cms_pkg::PH_START_POLL: begin
                if (i_item.driver_ok) n_phase = i2cms_pkg::PH_ADDR;
            end
            i2cms_pkg::PH_ADDR: n_phase = i2cms_pkg::PH_ADDR_POLL;
            i2cms_pkg::PH_ADDR_POLL: begin
                if (i_item.driver_ok) begin
                    if (e_wr_pend || !e_rd_pend) begin
                        n_phase = i2cms_pkg::PH_CLEAR;
                    end else begin
                        n_ret   = i2cms_pkg::PH_ADDR_POLL;
                        n_phase = i2cms_pkg::PH_GET_NEXT;
                    end
                end
            end
            i2cms_pkg::PH_CLEAR: begin
                if (e_wr_pend || !e_rd_pend) begin
                    n_phase = i2cms_pkg::PH_PLACE;
                end else begin
                    n_ret   = i2cms_pkg::PH_CLEAR;
                    n_phase = i2cms_pkg::PH_GET_NEXT;
                end
            end
            i2cms_pkg::PH_PLACE: n_phase = i2cms_pkg::PH_PLACE_POLL;
            i2cms_pkg::PH_PLACE_POLL: begin
                if (i_item.driver_ok) n_phase = i2cms_pkg::PH_PLACE_NEXT;
            end
            i2cms_pkg::PH_PLACE_NEXT: begin
                if (cnt_last) begin
                    n_phase   = i2cms_pkg::PH_IDLE;
                    n_wr_pend = 1'b0;
                    n_cnt     = 8'd0;
                    n_pos     = 8'd0;
                end else begin
                    n_cnt   = e_cnt - 8'd1;
                    n_pos   = e_pos + 8'd1;
                    n_phase = i2cms_pkg::PH_PLACE;
                end
            end
            i2cms_pkg::PH_GET_NEXT: begin
                case (r_ret)
                    i2cms_pkg::PH_ADDR_POLL: n_phase = i2cms_pkg::PH_CLEAR;
                    i2cms_pkg::PH_CLEAR: begin
                        n_phase = cnt_last ? i2cms_pkg::PH_LAST_POLL
                                           : i2cms_pkg::PH_MULTI_POLL;
                    end
                    i2cms_pkg::PH_LAST_GET: begin
                        n_phase   = i2cms_pkg::PH_IDLE;
                        n_ret     = i2cms_pkg::PH_UNINIT;
                        n_rd_pend = 1'b0;
                        n_cnt     = 8'd0;
                        n_pos     = 8'd0;
                    end
                    i2cms_pkg::PH_MULTI_GET: begin
                        if (!cnt_last) begin
                            n_cnt = e_cnt - 8'd1;
                            n_pos = e_pos + 8'd1;
                        end
                        // After the step down, one or fewer left means the last byte.
                        n_phase = (e_cnt <= 8'd2) ? i2cms_pkg::PH_LAST_POLL
                                                  : i2cms_pkg::PH_MULTI_POLL;
                    end
                    default: n_phase = i2cms_pkg::PH_IDLE;
                endcase
            end
            i2cms_pkg::PH_LAST_POLL: begin
                if (i_item.driver_ok) n_phase = i2cms_pkg::PH_LAST_GET;
            end
            i2cms_pkg::PH_LAST_GET: begin
                n_ret   = i2cms_pkg::PH_LAST_GET;
                n_phase = i2cms_pkg::PH_GET_NEXT;
            end
            i2cms_pkg::PH_MULTI_POLL: begin
                if (i_item.driver_ok) n_phase = i2cms_pkg::PH_MULTI_GET;
            end
            i2cms_pkg::PH_MULTI_GET: begin
                n_ret   = i2cms_pkg::PH_MULTI_GET;
                n_phase = i2cms_pkg::PH_GET_NEXT;
            end
            default: begin
                n_phase = i_item.init_done ? i2cms_pkg::PH_IDLE : i2cms_pkg::PH_UNINIT;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_result = '0;
        case (r_phase)
            i2cms_pkg::PH_START:      o_result.command = i2cms_pkg::CMD_START;
            i2cms_pkg::PH_START_POLL: o_result.command = i2cms_pkg::CMD_POLL_START;
            i2cms_pkg::PH_ADDR: begin
                if (e_wr_pend || e_rd_pend) begin
                    o_result.command        = i2cms_pkg::CMD_SEND_ADDR;
                    o_result.address_out    = e_addr;
                    o_result.read_not_write = !e_wr_pend;
                end
            end
            i2cms_pkg::PH_ADDR_POLL:  o_result.command = i2cms_pkg::CMD_POLL_ADDR;
            i2cms_pkg::PH_CLEAR:      o_result.command = i2cms_pkg::CMD_CLEAR_ADDR;
            i2cms_pkg::PH_PLACE: begin
                o_result.command    = i2cms_pkg::CMD_PLACE;
                o_result.byte_index = e_pos;
            end
            i2cms_pkg::PH_PLACE_POLL: o_result.command = i2cms_pkg::CMD_POLL_PLACE;
            i2cms_pkg::PH_PLACE_NEXT: o_result.tx_done = cnt_last;
            i2cms_pkg::PH_GET_NEXT: begin
                case (r_ret)
                    i2cms_pkg::PH_ADDR_POLL: begin
                        if (cnt_last) o_result.command = i2cms_pkg::CMD_ACK_OFF;
                    end
                    i2cms_pkg::PH_LAST_GET: begin
                        o_result.command = i2cms_pkg::CMD_ACK_ON;
                        o_result.rx_done = 1'b1;
                    end
                    i2cms_pkg::PH_MULTI_GET: begin
                        if (e_cnt <= 8'd2) o_result.command = i2cms_pkg::CMD_ACK_OFF;
                    end
                    default: o_result.command = i2cms_pkg::CMD_NONE;
                endcase
            end
            i2cms_pkg::PH_LAST_POLL,
            i2cms_pkg::PH_MULTI_POLL: o_result.command = i2cms_pkg::CMD_POLL_GET;
            i2cms_pkg::PH_LAST_GET,
            i2cms_pkg::PH_MULTI_GET: begin
                o_result.command    = i2cms_pkg::CMD_GET;
                o_result.byte_index = e_pos;
            end
            default: o_result.command = i2cms_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cms_pkg::PH_UNINIT;
            r_ret     <= i2cms_pkg::PH_UNINIT;
            r_wr_pend <= 1'b0;
            r_rd_pend <= 1'b0;
            r_addr    <= 7'd0;
            r_cnt     <= 8'd0;
            r_pos     <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_ret     <= n_ret;
            r_wr_pend <= n_wr_pend;
            r_rd_pend <= n_rd_pend;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
        end
    end

endmodule

@@ rtl/i2c_master_transfer_sequencer.sv @@
// Top level of the I2C master transfer sequencer: input register, phase
// machine and result register. Depends on i2cms_pkg and i2cms_fsm.
//
//  Channel   | Direction | Item
//  s_axis    | in        | one tick: init flag, request, driver status
//  m_axis    | out       | one driver command with index and done pulses
//
// Each accepted tick yields exactly one result, passed from the input register to
// the result register; a new tick can be taken every cycle while output is ready.
// The phase machine steps once per tick as it moves from the input register
// to the result register. A stalled output holds its result and the input
// register, and the input side stalls only when both registers are full and
// the output is not ready. Reset is synchronous and clears the phase to
// uninitialized and all pending flags.
module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // init_done[0], slave_address[7:1], byte_count[15:8], driver_ok[16], zero pad
    input  logic [23:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // address_out[6:0], read_not_write[7], byte_index[15:8], tx_done[16],
    // rx_done[17], zero pad
    output logic [23:0] o_m_axis_tdata,
    // command[3:0]
    output logic [3:0]  o_m_axis_tuser
);

    i2cms_pkg::t_in_item  r_in;
    logic                 r_in_valid;
    i2cms_pkg::t_out_item r_out;
    logic                 r_out_valid;
    i2cms_pkg::t_out_item step_result;
    logic                 step;
    logic                 in_take;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    i2cms_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.init_done     <= i_s_axis_tdata[0];
            r_in.slave_address <= i_s_axis_tdata[7:1];
            r_in.byte_count    <= i_s_axis_tdata[15:8];
            r_in.driver_ok     <= i_s_axis_tdata[16];
            r_in.req_type      <= i_s_axis_tuser;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.rx_done, r_out.tx_done, r_out.byte_index,
                              r_out.read_not_write, r_out.address_out};
    assign o_m_axis_tuser  = r_out.command;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the I2C master transfer sequencer: drives ticks on the
// input stream, predicts every driver command and checks it on the output stream.
// Depends on i2cms_pkg and the i2c_master_transfer_sequencer RTL.

class command_scoreboard;
    i2cms_pkg::t_phase    phase;
    i2cms_pkg::t_phase    return_phase;
    logic                 wr_pending;
    logic                 rd_pending;
    logic [6:0]           target;
    logic [7:0]           remaining;
    logic [7:0]           position;
    i2cms_pkg::t_out_item expected_cmds[$];
    int                   errors;

    function new();
        phase        = i2cms_pkg::PH_UNINIT;
        return_phase = i2cms_pkg::PH_UNINIT;
        wr_pending   = 1'b0;
        rd_pending   = 1'b0;
        target       = '0;
        remaining    = '0;
        position     = '0;
        errors       = 0;
    endfunction

    // One step of the phase machine: latch a new request, then advance once.
    function i2cms_pkg::t_out_item next_command(i2cms_pkg::t_in_item it);
        i2cms_pkg::t_out_item r;
        r = '0;
        r.command = i2cms_pkg::CMD_NONE;
        if ((it.req_type == i2cms_pkg::REQ_WRITE || it.req_type == i2cms_pkg::REQ_READ) &&
            it.byte_count != 8'd0) begin
            if (it.req_type == i2cms_pkg::REQ_WRITE) wr_pending = 1'b1;
            else rd_pending = 1'b1;
            target    = it.slave_address;
            remaining = it.byte_count;
            position  = 8'd0;
        end
        case (phase)
            i2cms_pkg::PH_IDLE: begin
                if (wr_pending || rd_pending) phase = i2cms_pkg::PH_START;
            end
            i2cms_pkg::PH_START: begin
                r.command = i2cms_pkg::CMD_START;
                phase = i2cms_pkg::PH_START_POLL;
            end
            i2cms_pkg::PH_START_POLL: begin
                r.command = i2cms_pkg::CMD_POLL_START;
                if (it.driver_ok) phase = i2cms_pkg::PH_ADDR;
            end
            i2cms_pkg::PH_ADDR: begin
                if (wr_pending || rd_pending) begin
                    r.command        = i2cms_pkg::CMD_SEND_ADDR;
                    r.address_out    = target;
                    r.read_not_write = !wr_pending;
                end
                phase = i2cms_pkg::PH_ADDR_POLL;
            end
            i2cms_pkg::PH_ADDR_POLL: begin
                r.command = i2cms_pkg::CMD_POLL_ADDR;
                if (it.driver_ok) begin
                    if (wr_pending || !rd_pending) begin
                        phase = i2cms_pkg::PH_CLEAR;
                    end else begin
                        return_phase = i2cms_pkg::PH_ADDR_POLL;
                        phase = i2cms_pkg::PH_GET_NEXT;
                    end
                end
            end
            i2cms_pkg::PH_CLEAR: begin
                r.command = i2cms_pkg::CMD_CLEAR_ADDR;
                if (wr_pending || !rd_pending) begin
                    phase = i2cms_pkg::PH_PLACE;
                end else begin
                    return_phase = i2cms_pkg::PH_CLEAR;
                    phase = i2cms_pkg::PH_GET_NEXT;
                end
            end
            i2cms_pkg::PH_PLACE: begin
                r.command    = i2cms_pkg::CMD_PLACE;
                r.byte_index = position;
                phase = i2cms_pkg::PH_PLACE_POLL;
            end
            i2cms_pkg::PH_PLACE_POLL: begin
                r.command = i2cms_pkg::CMD_POLL_PLACE;
                if (it.driver_ok) phase = i2cms_pkg::PH_PLACE_NEXT;
            end
            i2cms_pkg::PH_PLACE_NEXT: begin
                if (remaining <= 8'd1) begin
                    phase      = i2cms_pkg::PH_IDLE;
                    wr_pending = 1'b0;
                    remaining  = 8'd0;
                    position   = 8'd0;
                    r.tx_done  = 1'b1;
                end else begin
                    remaining = remaining - 8'd1;
                    position  = position + 8'd1;
                    phase = i2cms_pkg::PH_PLACE;
                end
            end
            i2cms_pkg::PH_GET_NEXT: begin
                case (return_phase)
                    i2cms_pkg::PH_ADDR_POLL: begin
                        if (remaining <= 8'd1) r.command = i2cms_pkg::CMD_ACK_OFF;
                        phase = i2cms_pkg::PH_CLEAR;
                    end
                    i2cms_pkg::PH_CLEAR: begin
                        phase = (remaining <= 8'd1) ? i2cms_pkg::PH_LAST_POLL
                                                    : i2cms_pkg::PH_MULTI_POLL;
                    end
                    i2cms_pkg::PH_LAST_GET: begin
                        phase        = i2cms_pkg::PH_IDLE;
                        return_phase = i2cms_pkg::PH_UNINIT;
                        rd_pending   = 1'b0;
                        remaining    = 8'd0;
                        position     = 8'd0;
                        r.command    = i2cms_pkg::CMD_ACK_ON;
                        r.rx_done    = 1'b1;
                    end
                    i2cms_pkg::PH_MULTI_GET: begin
                        if (remaining > 8'd1) begin
                            remaining = remaining - 8'd1;
                            position  = position + 8'd1;
                        end
                        if (remaining <= 8'd1) begin
                            r.command = i2cms_pkg::CMD_ACK_OFF;
                            phase = i2cms_pkg::PH_LAST_POLL;
                        end else begin
                            phase = i2cms_pkg::PH_MULTI_POLL;
                        end
                    end
                    default: phase = i2cms_pkg::PH_IDLE;
                endcase
            end
            i2cms_pkg::PH_LAST_POLL: begin
                r.command = i2cms_pkg::CMD_POLL_GET;
                if (it.driver_ok) phase = i2cms_pkg::PH_LAST_GET;
            end
            i2cms_pkg::PH_LAST_GET: begin
                r.command    = i2cms_pkg::CMD_GET;
                r.byte_index = position;
                return_phase = i2cms_pkg::PH_LAST_GET;
                phase = i2cms_pkg::PH_GET_NEXT;
            end
            i2cms_pkg::PH_MULTI_POLL: begin
                r.command = i2cms_pkg::CMD_POLL_GET;
                if (it.driver_ok) phase = i2cms_pkg::PH_MULTI_GET;
            end
            i2cms_pkg::PH_MULTI_GET: begin
                r.command    = i2cms_pkg::CMD_GET;
                r.byte_index = position;
                return_phase = i2cms_pkg::PH_MULTI_GET;
                phase = i2cms_pkg::PH_GET_NEXT;
            end
            default: phase = it.init_done ? i2cms_pkg::PH_IDLE : i2cms_pkg::PH_UNINIT;
        endcase
        return r;
    endfunction

    function void note_tick(i2cms_pkg::t_in_item it);
        expected_cmds.push_back(next_command(it));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_command(i2cms_pkg::t_out_item got);
        i2cms_pkg::t_out_item want;
        if (expected_cmds.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = expected_cmds.pop_front();
        compare_field("command", 8'(want.command), 8'(got.command));
        compare_field("address_out", 8'(want.address_out), 8'(got.address_out));
        compare_field("read_not_write", 8'(want.read_not_write), 8'(got.read_not_write));
        compare_field("byte_index", want.byte_index, got.byte_index);
        compare_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
        compare_field("rx_done", 8'(want.rx_done), 8'(got.rx_done));
    endfunction
endclass

module tb_top;
    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         RANDOM_TICKS = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    command_scoreboard board = new();
    int ticks_sent = 0;

    always #5 clk = ~clk;

    i2c_master_transfer_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    function automatic i2cms_pkg::t_in_item make_tick(logic init, logic [1:0] req,
                                                      logic [6:0] addr, logic [7:0] cnt,
                                                      logic ok);
        i2cms_pkg::t_in_item it;
        it.init_done     = init;
        it.req_type      = req;
        it.slave_address = addr;
        it.byte_count    = cnt;
        it.driver_ok     = ok;
        return it;
    endfunction

    // Offer one tick, with a random gap except in the stretches that run flat out.
    task automatic drive_tick(i2cms_pkg::t_in_item it);
        int gap;
        gap = ((ticks_sent / 100) % 4 == 2) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.driver_ok, it.byte_count, it.slave_address, it.init_done};
        s_tuser  <= it.req_type;
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_tick(it);
        ticks_sent++;
    endtask

    // Receiver: random stalls, stretches without stalls, and one long hold-off
    // that lets both internal registers fill so that the input side stalls.
    initial begin
        int hold;
        int seen;
        i2cms_pkg::t_out_item got;
        seen = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (seen == 300) hold = 250;
            else if ((seen / 100) % 4 == 1) hold = 0;
            else hold = $urandom_range(0, 8);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.command        = i2cms_pkg::t_cmd'(m_tuser);
            got.address_out    = m_tdata[6:0];
            got.read_not_write = m_tdata[7];
            got.byte_index     = m_tdata[15:8];
            got.tx_done        = m_tdata[16];
            got.rx_done        = m_tdata[17];
            board.check_command(got);
            seen++;
        end
    end

    initial begin
        logic [1:0] req;
        logic [7:0] cnt;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Held uninitialized, code three and a zero count are all ignored.
        drive_tick(make_tick(1'b0, REQ_NONE, 7'd0, 8'd0, 1'b0));
        drive_tick(make_tick(1'b0, REQ_UNUSED, 7'd127, 8'd255, 1'b1));
        drive_tick(make_tick(1'b1, i2cms_pkg::REQ_WRITE, 7'd127, 8'd0, 1'b1));
        drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b0));
        // A read, then a write that overrides it while busy and wins priority.
        drive_tick(make_tick(1'b1, i2cms_pkg::REQ_READ, 7'd0, 8'd1, 1'b0));
        drive_tick(make_tick(1'b1, i2cms_pkg::REQ_WRITE, 7'd127, 8'd2, 1'b0));
        drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b0));
        drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b1));
        drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b1));
        drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b0));
        repeat (8) drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b1));
        // The read is still pending with its count used up: it takes one byte.
        repeat (7) drive_tick(make_tick(1'b1, REQ_NONE, 7'd0, 8'd0, 1'b1));

        for (int i = 0; i < RANDOM_TICKS; i++) begin
            req = REQ_NONE;
            cnt = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 59) == 0) begin
                req = REQ_UNUSED;
            end else if ($urandom_range(0, 14) == 0) begin
                req = $urandom_range(0, 1) ? i2cms_pkg::REQ_WRITE : i2cms_pkg::REQ_READ;
                case ($urandom_range(0, 19))
                    0:       cnt = 8'd0;
                    1:       cnt = 8'($urandom_range(17, 255));
                    2, 3, 4: cnt = 8'($urandom_range(5, 16));
                    default: cnt = 8'($urandom_range(1, 4));
                endcase
            end
            drive_tick(make_tick($urandom_range(0, 19) != 0, req,
                                 7'($urandom_range(0, 127)), cnt,
                                 $urandom_range(0, 4) != 0));
        end
        s_tvalid <= 1'b0;

        while (board.expected_cmds.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.expected_cmds.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top failed");
        $finish;
    end
endmodule

@@ files.f @@
rtl/i2cms_pkg.sv
rtl/i2cms_fsm.sv
rtl/i2c_master_transfer_sequencer.sv
bench/tb_top.sv
